[src/assert_macros.svh]
// Assertion macros shared by the text console RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

[src/tcw_pkg.sv]
// Package for the text console character writer: geometry, field widths,
// command and character codes, sequencer states and the cell address helper.
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = ROWS * COLUMNS;
   localparam int SCROLL_SPAN = (ROWS - 1) * COLUMNS;

   // Field widths.
   localparam int ADDR_W = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;
   localparam int CMD_W  = 2;

   // Character codes.
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
   localparam logic [CHAR_W-1:0] PRINT_LAST     = 8'h7F;

   // Tab stops fall on multiples of eight columns.
   localparam int                TAB_WIDTH = 8;
   localparam logic [COL_W-1:0]  TAB_MASK  = ~COL_W'(TAB_WIDTH - 1);

   // Attribute after reset and the blank cell that reset fills with.
   localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
   localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, SPACE_CODE};

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_FILL,
      ST_SCROLL,
      ST_DONE
   } state_type;

   // Linear cell address of a row and column.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

[src/tcw_channels.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on tcw_pkg for the field widths.
`default_nettype none

// Request channel: one command with its character and cell index.
interface tcw_req_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAR_W-1:0] char_code;
   logic [ADDR_W-1:0] cell_index;

   modport source (output valid, command, char_code, cell_index, input ready);
   modport sink   (input valid, command, char_code, cell_index, output ready);
endinterface

// Response channel: cursor after the command and the cell that was read.
interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] cursor_location;
   logic [ROW_W-1:0]  cursor_line;
   logic [COL_W-1:0]  cursor_column;
   logic [CELL_W-1:0] cell_data;

   modport source (output valid, cursor_location, cursor_line, cursor_column, cell_data,
                   input ready);
   modport sink   (input valid, cursor_location, cursor_line, cursor_column, cell_data,
                   output ready);
endinterface

`default_nettype wire

[src/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/text_console_char_writer_top.sv]
// Text console character writer: cursor sequencer around the cell store RAM.
// Depends on tcw_pkg, tcw_channels (interfaces), tcw_ram and assert_macros.svh.
//
// Usage
//   Commands arrive on the request channel and each yields exactly one
//   transfer on the response channel with the cursor after the command and,
//   for a read, the stored cell (attribute high byte, character low byte).
//   The user must write the attribute register, through csr_write_enable and
//   csr_write_data, only while the block is idle; the block does not check.
//   One command is in work at a time; req_chan.ready is high only when the
//   sequencer is idle. A plain character or cursor control passes from the
//   idle state through the done state to the response register; a cell read
//   also passes through the read state. Clear screen walks the store at one
//   cell per cycle. A character that moves past the last row scrolls the
//   store, one cell per cycle through the single RAM read and write port.
//   After reset the store is filled with blanks of attribute 0x0F, one cell
//   per cycle: no request is taken until the fill is done.
//   The response sits in an output register; a new request is taken while it
//   waits, but the next response is held back until the receiver has taken
//   the earlier one.
`default_nettype none
`include "assert_macros.svh"

module text_console_char_writer_top import tcw_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   tcw_req_if.sink                req_chan,
   tcw_rsp_if.source              rsp_chan,
   input  wire logic              csr_write_enable,
   input  wire logic [ATTR_W-1:0] csr_write_data
);

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ATTR_W-1:0] attr_ff;
   logic [CELL_W-1:0] data_ff, data_in;
   logic              in_range_ff, in_range_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              wr_copy_ff, wr_copy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_loc_ff, rsp_loc_in;
   logic [ROW_W-1:0]  rsp_line_ff, rsp_line_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [COL_W-1:0]  col_put;
   logic [ROW_W-1:0]  row_put;
   logic              printable;
   logic [CELL_W-1:0] blank;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   // Cell store.
   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign blank          = {attr_ff, SPACE_CODE};
   assign printable      = req_chan.char_code inside {[SPACE_CODE:PRINT_LAST]};

   // Cursor movement for a put command, including column wrap.
   always_comb begin
      col_put = col_ff;
      row_put = row_ff;
      if (req_chan.char_code == CHAR_BACKSPACE) begin
         if (col_ff != '0) begin
            col_put = col_ff - COL_W'(1);
         end
      end else if (req_chan.char_code == CHAR_TAB) begin
         col_put = (col_ff + COL_W'(TAB_WIDTH)) & TAB_MASK;
      end else if (req_chan.char_code == CHAR_CR) begin
         col_put = '0;
      end else if (req_chan.char_code == CHAR_LF) begin
         col_put = '0;
         row_put = row_ff + ROW_W'(1);
      end else if (printable) begin
         col_put = col_ff + COL_W'(1);
      end
      if (col_put >= COL_W'(COLUMNS)) begin
         col_put = '0;
         row_put = row_put + ROW_W'(1);
      end
   end

   // Sequencer: next state, store accesses and response loading.
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      in_range_in  = in_range_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_copy_in   = wr_copy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_loc_in   = rsp_loc_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = blank;
      ram_raddr    = req_chan.cell_index;

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_BLANK;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               data_in = '0;
               case (req_chan.command)
                  CMD_PUT: begin
                     if (printable) begin
                        ram_we    = 1'b1;
                        ram_waddr = cell_addr(row_ff, col_ff);
                        ram_wdata = {attr_ff, req_chan.char_code};
                     end
                     col_in = col_put;
                     if (row_put >= ROW_W'(ROWS)) begin
                        row_in   = ROW_W'(ROWS - 1);
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in   = row_put;
                        state_in = ST_DONE;
                     end
                  end
                  CMD_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  CMD_READ: begin
                     in_range_in = (req_chan.cell_index < ADDR_W'(CELL_COUNT));
                     state_in    = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            data_in  = in_range_ff ? ram_rdata : '0;
            state_in = ST_DONE;
         end
         ST_FILL: begin
            ram_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_SCROLL: begin
            // Read the cell one row below (bottom row: blank); it is written back in the next cycle.
            wr_pend_in = 1'b1;
            wr_addr_in = cnt_ff;
            wr_copy_in = (cnt_ff < ADDR_W'(SCROLL_SPAN));
            ram_raddr  = wr_copy_in ? cnt_ff + ADDR_W'(COLUMNS) : cnt_ff;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_loc_in   = cell_addr(row_ff, col_ff);
               rsp_line_in  = row_ff;
               rsp_col_in   = col_ff;
               rsp_data_in  = data_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Delayed write of a scroll step: moved cell or blank for the bottom row.
      if (wr_pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = wr_addr_ff;
         ram_wdata = wr_copy_ff ? ram_rdata : blank;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      in_range_ff <= in_range_in;
      wr_addr_ff  <= wr_addr_in;
      wr_copy_ff  <= wr_copy_in;
      rsp_loc_ff  <= rsp_loc_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.cursor_location = rsp_loc_ff;
   assign rsp_chan.cursor_line     = rsp_line_ff;
   assign rsp_chan.cursor_column   = rsp_col_ff;
   assign rsp_chan.cell_data       = rsp_data_ff;

   // Checks on the sequencer.
   `ASSERT_IMPLIES(a_col_in_range, clock, reset, state_ff == ST_IDLE,
      col_ff < COL_W'(COLUMNS), "cursor column beyond the last column while idle")
   `ASSERT_IMPLIES(a_row_in_range, clock, reset, state_ff == ST_IDLE,
      row_ff < ROW_W'(ROWS), "cursor row beyond the last row while idle")
   `ASSERT_IMPLIES(a_scroll_write, clock, reset, wr_pend_ff,
      state_ff == ST_SCROLL || state_ff == ST_DONE, "scroll write pending outside a scroll")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept,
      state_ff != ST_IDLE, "sequencer idle straight after a request transfer")

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for text_console_char_writer_top: a cursor and cell-store predictor
// checks every response.
// Depends on tcw_pkg, the tcw_req_if and tcw_rsp_if channels and the top-level RTL.

module tb import tcw_pkg::*; ();

   // Cursor and cell contents reported for one command.
   typedef struct packed {
      logic [ADDR_W-1:0] location;
      logic [ROW_W-1:0]  line;
      logic [COL_W-1:0]  column;
      logic [CELL_W-1:0] cell_value;
   } cursor_report_type;

   // The scoreboard keeps its own copy of the screen, the cursor and the attribute.
   class console_scoreboard;
      logic [CELL_W-1:0] screen [CELL_COUNT];
      int unsigned       row_now;
      int unsigned       col_now;
      logic [ATTR_W-1:0] attribute;
      cursor_report_type expected_reports [$];
      int                mismatches;

      function new();
         attribute  = RESET_ATTR;
         row_now    = 0;
         col_now    = 0;
         mismatches = 0;
         blank_range(0, CELL_COUNT);
      endfunction

      function void blank_range(int from, int upto);
         for (int i = from; i < upto; i++) screen[i] = {attribute, SPACE_CODE};
      endfunction

      // Apply one accepted command and queue the response that it should give.
      function void note_command(command_type cmd, logic [CHAR_W-1:0] code,
                                 logic [ADDR_W-1:0] index);
         cursor_report_type rpt;
         rpt.cell_value = '0;
         case (cmd)
            CMD_PUT: begin
               if (code == CHAR_BACKSPACE) begin
                  if (col_now != 0) col_now--;
               end else if (code == CHAR_TAB) begin
                  col_now = (col_now + TAB_WIDTH) & ~(TAB_WIDTH - 1);
               end else if (code == CHAR_CR) begin
                  col_now = 0;
               end else if (code == CHAR_LF) begin
                  col_now = 0;
                  row_now++;
               end else if (code >= SPACE_CODE && code <= PRINT_LAST) begin
                  screen[row_now * COLUMNS + col_now] = {attribute, code};
                  col_now++;
               end
               // Running off the last column wraps to the next row.
               if (col_now >= COLUMNS) begin
                  col_now = 0;
                  row_now++;
               end
               // Running off the last row scrolls up one line.
               if (row_now >= ROWS) begin
                  for (int i = 0; i < SCROLL_SPAN; i++) screen[i] = screen[i + COLUMNS];
                  blank_range(SCROLL_SPAN, CELL_COUNT);
                  row_now = ROWS - 1;
               end
            end
            CMD_CLEAR: begin
               blank_range(0, CELL_COUNT);
               row_now = 0;
               col_now = 0;
            end
            CMD_READ: begin
               if (index < CELL_COUNT) rpt.cell_value = screen[index];
            end
            default: ;
         endcase
         rpt.location = ADDR_W'(row_now * COLUMNS + col_now);
         rpt.line     = ROW_W'(row_now);
         rpt.column   = COL_W'(col_now);
         expected_reports.push_back(rpt);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, wanted 0x%0h", name, got, want));
      endtask

      // Compare one response transfer with the oldest outstanding expectation.
      task check_report(cursor_report_type got);
         cursor_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("response with no command outstanding, location %0d",
                                      got.location));
            return;
         end
         want = expected_reports.pop_front();
         compare_field("cursor_location", got.location, want.location);
         compare_field("cursor_line", got.line, want.line);
         compare_field("cursor_column", got.column, want.column);
         compare_field("cell_data", got.cell_value, want.cell_value);
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ATTR_W-1:0] csr_write_data;

   tcw_req_if req_if();
   tcw_rsp_if rsp_if();

   text_console_char_writer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   console_scoreboard sb = new();
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_left          = 0;
   cursor_report_type seen;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous ceiling on the whole run.
   initial begin
      #100_000_000;
      $display("** text_console_char_writer_top: FAILED **");
      $finish;
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Watch both channels and pass every transfer to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_command(command_type'(req_if.command), req_if.char_code,
                            req_if.cell_index);
         if (rsp_if.valid && rsp_if.ready) begin
            seen.location   = rsp_if.cursor_location;
            seen.line       = rsp_if.cursor_line;
            seen.column     = rsp_if.cursor_column;
            seen.cell_value = rsp_if.cell_data;
            sb.check_report(seen);
         end
      end
   end

   // Offer one command, after a random idle gap, and wait for its transfer.
   task automatic send_request(command_type cmd, logic [CHAR_W-1:0] code,
                               logic [ADDR_W-1:0] index);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.char_code  <= code;
      req_if.cell_index <= index;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stop offering and wait until every outstanding response has arrived.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_reports.size() != 0);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.attribute = value;
   endtask

   // Random command, weighted towards text and line feeds so that the cursor
   // wraps and the screen scrolls often, with reads aimed near the cursor.
   task automatic pick_command(output command_type cmd, output logic [CHAR_W-1:0] code,
                               output logic [ADDR_W-1:0] index);
      int roll;
      int near;
      roll  = $urandom_range(0, 999);
      cmd   = CMD_PUT;
      code  = CHAR_W'($urandom_range(0, 255));
      index = ADDR_W'($urandom_range(0, 2047));
      if (roll < 600) begin
         code = CHAR_W'($urandom_range(SPACE_CODE, PRINT_LAST));
      end else if (roll < 680) begin
         code = CHAR_LF;
      end else if (roll < 720) begin
         code = CHAR_CR;
      end else if (roll < 760) begin
         code = CHAR_TAB;
      end else if (roll < 790) begin
         code = CHAR_BACKSPACE;
      end else if (roll < 830) begin
         // Low control codes (mostly ignored, some cursor controls) and the upper half (ignored).
         code = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 31))
                                     : CHAR_W'($urandom_range(128, 255));
      end else if (roll < 960) begin
         cmd = CMD_READ;
         case ($urandom_range(0, 3))
            0: index = ADDR_W'($urandom_range(0, 2047));
            1: index = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
            default: begin
               near  = int'(sb.row_now * COLUMNS + sb.col_now) - int'($urandom_range(0, 100));
               index = ADDR_W'(near < 0 ? 0 : near);
            end
         endcase
      end else if (roll < 965) begin
         cmd = CMD_CLEAR;
      end else if (roll < 985) begin
         cmd = CMD_NOP;
      end
   endtask

   task automatic run_phase(logic [ATTR_W-1:0] attr, int idle_pct, int stall_pct,
                            int count, bit long_hold);
      command_type       cmd;
      logic [CHAR_W-1:0] code;
      logic [ADDR_W-1:0] index;
      drain_responses();
      write_attribute(attr);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (long_hold) hold_left = 300;
      repeat (count) begin
         pick_command(cmd, code, index);
         send_request(cmd, code, index);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.command    <= CMD_PUT;
      req_if.char_code  <= '0;
      req_if.cell_index <= '0;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The block blanks its store after reset before it takes a command.
      do @(posedge clock); while (req_if.ready !== 1'b1);

      // Directed commands under the reset attribute.
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd1999);
      send_request(CMD_PUT, 8'h41, 11'd0);
      send_request(CMD_NOP, 8'hFF, 11'd2047);
      drain_responses();

      // Directed commands: edges of the printable range, cursor controls, ignored bytes, reads and a clear.
      write_attribute(8'hC3);
      send_request(CMD_PUT, SPACE_CODE, 11'd0);
      send_request(CMD_PUT, PRINT_LAST, 11'd0);
      send_request(CMD_PUT, CHAR_BACKSPACE, 11'd0);
      send_request(CMD_PUT, CHAR_CR, 11'd0);
      send_request(CMD_PUT, CHAR_BACKSPACE, 11'd0);
      send_request(CMD_PUT, CHAR_TAB, 11'd0);
      send_request(CMD_PUT, CHAR_LF, 11'd0);
      send_request(CMD_PUT, 8'h00, 11'd0);
      send_request(CMD_PUT, 8'h1F, 11'd0);
      send_request(CMD_PUT, 8'h80, 11'd0);
      send_request(CMD_PUT, 8'hFF, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd2);
      send_request(CMD_READ, 8'h00, 11'd2000);
      send_request(CMD_READ, 8'h00, 11'd2047);
      send_request(CMD_CLEAR, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd0);

      // Random phases, each under its own attribute and idling pattern.
      run_phase(8'hFF, 0, 0, 210, 1'b0);
      run_phase(8'h00, 47, 0, 210, 1'b0);
      run_phase(ATTR_W'($urandom_range(0, 255)), 0, 47, 210, 1'b1);
      run_phase(ATTR_W'($urandom_range(0, 255)), 25, 25, 210, 1'b0);

      receiver_stall_pct = 0;
      drain_responses();
      repeat (2100) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("** text_console_char_writer_top: PASSED **");
      end else begin
         $display("** text_console_char_writer_top: FAILED **");
      end
      $finish;
   end

endmodule
